// ----- rtl/core/acms_pkg.sv -----
// Shared types, codes and constants for the decimal accumulator machine.
package acms_pkg;

    localparam int MEM_WORDS_DEF = 32;
    localparam int RADIX         = 100;

    // Reciprocal of the radix: (x * DIV_RECIP) >> DIV_SHIFT equals x / 100 for any
    // unsigned x below 2**32, so it is exact for the 31-bit magnitude of a word.
    localparam logic [30:0] DIV_RECIP = 31'h51EB_851F;
    localparam int          DIV_SHIFT = 37;
    localparam int          PROD_W    = 62;
    localparam int          QUOT_W    = PROD_W - DIV_SHIFT;

    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_EXEC    = 2'd1;
    localparam logic [1:0] MODE_RESTART = 2'd2;
    localparam logic [1:0] MODE_READ    = 2'd3;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_HALTED      = 3'd1;
    localparam logic [2:0] ST_BAD_OPCODE  = 3'd2;
    localparam logic [2:0] ST_BAD_OPERAND = 3'd3;
    localparam logic [2:0] ST_BAD_PC      = 3'd4;

    localparam logic [5:0] OP_READ      = 6'd10;
    localparam logic [5:0] OP_WRITE     = 6'd11;
    localparam logic [5:0] OP_LOAD      = 6'd20;
    localparam logic [5:0] OP_STORE     = 6'd21;
    localparam logic [5:0] OP_ADD       = 6'd30;
    localparam logic [5:0] OP_SUBTRACT  = 6'd31;
    localparam logic [5:0] OP_BRANCHNEG = 6'd41;
    localparam logic [5:0] OP_HALT      = 6'd43;

    typedef struct packed {
        logic [1:0]         mode;
        logic [4:0]         address;
        logic signed [31:0] value;
    } t_item;

    typedef struct packed {
        logic [2:0]         status;
        logic               out_valid;
        logic signed [31:0] out_value;
        logic               input_used;
        logic [5:0]         pc_now;
        logic signed [31:0] acc_now;
        logic signed [31:0] read_data;
    } t_result;

    typedef enum logic [1:0] {
        RD_PC,
        RD_ADDR,
        RD_OPND
    } t_rd_src;

    typedef struct packed {
        logic    capture;
        logic    rd_en;
        t_rd_src rd_src;
        logic    mul_en;
        logic    dec_en;
        logic    exec_en;
        logic    load_en;
        logic    restart_en;
        logic    report_en;
    } t_ctl_cmd;

endpackage

// ----- rtl/core/accumulator_machine_step.sv -----
// Top level of the decimal accumulator machine: controller plus datapath.
//
// One command word goes in on start while busy is low; it is taken on that
// clock edge. The command either loads a memory word, executes one
// instruction at the program counter, clears pc and accumulator, or reads a
// memory word back. Every command yields exactly one result word on o_result,
// marked by o_done for a single cycle; the receiver cannot hold it off.
// Busy drops in the cycle that shows o_done, so a new command may be accepted
// there. Execute steps through the single memory port (fetch, then operand
// read and the write-back) and through the two-step reciprocal divide that
// splits the word into opcode and operand.
// Reset is synchronous and active low. It clears pc, accumulator and every
// memory word at once through per-word valid bits, so no clearing pass is
// needed and the block is ready in the first cycle after reset.
// Faults (bad pc, bad opcode, operand out of range) report a status and leave
// all state unchanged; halt reports halted and keeps pc on the halt word.
module accumulator_machine_step #(
    parameter int MEMORY_WORDS = acms_pkg::MEM_WORDS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  acms_pkg::t_item   i_item,
    output logic              o_done,
    output acms_pkg::t_result o_result
);
    import acms_pkg::*;

    t_ctl_cmd cmd;

    // The controller sequences the steps; it sees only the mode of the word.
    acms_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_mode  (i_item.mode),
        .o_busy  (busy),
        .o_done  (o_done),
        .o_cmd   (cmd)
    );

    // The datapath owns all architectural state and the result register.
    acms_dpath #(
        .MEMORY_WORDS (MEMORY_WORDS)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_item   (i_item),
        .o_result (o_result)
    );

    // A result is only ever shown while the block is ready for the next word.
    a_done_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // An accepted word always starts work on the next cycle.
    a_accept_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not start");

    // Status codes stay within the defined set.
    a_status_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.status <= ST_BAD_PC))
        else $error("status code out of range");

    // An emitted value comes only from a successful write instruction.
    a_write_ok : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.out_valid) |->
            (o_result.status == ST_OK && !o_result.input_used))
        else $error("output value with a fault or a read");

endmodule

// ----- rtl/core/acms_ctrl.sv -----
// Sequencing state machine of the accumulator machine.
module acms_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [1:0]        i_mode,
    output logic              o_busy,
    output logic              o_done,
    output acms_pkg::t_ctl_cmd o_cmd
);
    import acms_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH,
        S_MUL,
        S_DEC,
        S_EXEC,
        S_LOAD,
        S_RESTART,
        S_RDMEM,
        S_REPORT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_done;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_mode)
                        MODE_LOAD:    n_state = S_LOAD;
                        MODE_EXEC:    n_state = S_FETCH;
                        MODE_RESTART: n_state = S_RESTART;
                        default:      n_state = S_RDMEM;
                    endcase
                end
            end
            S_FETCH:   n_state = S_MUL;
            S_MUL:     n_state = S_DEC;
            S_DEC:     n_state = S_EXEC;
            S_RDMEM:   n_state = S_REPORT;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.rd_src = RD_PC;
        case (r_state)
            S_IDLE:    o_cmd.capture = i_start;
            S_FETCH: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_src = RD_PC;
            end
            S_MUL:     o_cmd.mul_en = 1'b1;
            S_DEC: begin
                o_cmd.dec_en = 1'b1;
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_src = RD_OPND;
            end
            S_EXEC:    o_cmd.exec_en = 1'b1;
            S_LOAD:    o_cmd.load_en = 1'b1;
            S_RESTART: o_cmd.restart_en = 1'b1;
            S_RDMEM: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_src = RD_ADDR;
            end
            S_REPORT:  o_cmd.report_en = 1'b1;
            default:   o_cmd.capture = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            // The result word lands in the datapath register on the same edge.
            r_done  <= (r_state != S_IDLE) && (n_state == S_IDLE);
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

// ----- rtl/core/acms_dpath.sv -----
// Datapath of the accumulator machine: memory, pc, accumulator, decoder, result.
module acms_dpath #(
    parameter int MEMORY_WORDS = acms_pkg::MEM_WORDS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  acms_pkg::t_ctl_cmd i_cmd,
    input  acms_pkg::t_item    i_item,
    output acms_pkg::t_result  o_result
);
    import acms_pkg::*;

    localparam int AW = $clog2(MEMORY_WORDS);
    localparam int PW = $clog2(MEMORY_WORDS + 1);

    logic [31:0]             mem [MEMORY_WORDS];
    logic [MEMORY_WORDS-1:0] r_valid;
    logic [31:0]             r_mem_q;
    logic                    r_mem_ok;

    t_item              r_item;
    logic [PW-1:0]      r_pc;
    logic signed [31:0] r_acc;
    logic signed [31:0] r_word;
    logic [PROD_W-1:0]  r_prod;
    logic [5:0]         r_opc;
    logic [6:0]         r_opnd;
    logic [2:0]         r_dec_st;
    t_result            r_res;
    t_result            n_res;

    logic               pc_ok;
    logic               addr_ok;
    logic signed [31:0] mem_word;
    logic [AW-1:0]      rd_idx;
    logic               rd_ok;
    logic               wr_en;
    logic [AW-1:0]      wr_idx;
    logic [31:0]        wr_data;

    logic [QUOT_W-1:0]  quot;
    logic [30:0]        quot_x100;
    logic [30:0]        rem;
    logic [6:0]         opnd_c;
    logic [2:0]         dec_st_c;

    logic [PW-1:0]      pc_inc;
    logic [PW-1:0]      x_pc;
    logic signed [31:0] x_acc;
    logic               x_out_valid;
    logic               x_input_used;

    assign pc_ok    = 32'(r_pc) < MEMORY_WORDS;
    assign addr_ok  = 32'(r_item.address) < MEMORY_WORDS;
    assign mem_word = r_mem_ok ? $signed(r_mem_q) : 32'sd0;
    assign pc_inc   = r_pc + PW'(1);

    // Split the fetched word into opcode and operand.
    assign quot      = r_prod[PROD_W-1:DIV_SHIFT];
    assign quot_x100 = 31'(quot) * 31'(RADIX);
    assign rem       = r_word[30:0] - quot_x100;
    assign opnd_c    = rem[6:0];

    always_comb begin
        if (!pc_ok) begin
            dec_st_c = ST_BAD_PC;
        end else if (r_word[31]) begin
            dec_st_c = ST_BAD_OPCODE;
        end else if (quot == QUOT_W'(OP_HALT)) begin
            dec_st_c = ST_HALTED;
        end else if (32'(opnd_c) >= MEMORY_WORDS) begin
            dec_st_c = ST_BAD_OPERAND;
        end else if (quot inside {QUOT_W'(OP_READ), QUOT_W'(OP_WRITE), QUOT_W'(OP_LOAD),
                                  QUOT_W'(OP_STORE), QUOT_W'(OP_ADD),
                                  QUOT_W'(OP_SUBTRACT), QUOT_W'(OP_BRANCHNEG)}) begin
            dec_st_c = ST_OK;
        end else begin
            dec_st_c = ST_BAD_OPCODE;
        end
    end

    always_comb begin
        case (i_cmd.rd_src)
            RD_PC: begin
                rd_idx = AW'(r_pc);
                rd_ok  = pc_ok;
            end
            RD_ADDR: begin
                rd_idx = AW'(r_item.address);
                rd_ok  = addr_ok;
            end
            RD_OPND: begin
                rd_idx = AW'(opnd_c);
                rd_ok  = (dec_st_c == ST_OK);
            end
            default: begin
                rd_idx = '0;
                rd_ok  = 1'b0;
            end
        endcase
    end

    // Instruction execution; faults leave pc and accumulator alone.
    always_comb begin
        x_pc         = r_pc;
        x_acc        = r_acc;
        x_out_valid  = 1'b0;
        x_input_used = 1'b0;
        if (r_dec_st == ST_OK) begin
            x_pc = pc_inc;
            case (r_opc)
                OP_READ:     x_input_used = 1'b1;
                OP_WRITE:    x_out_valid = 1'b1;
                OP_LOAD:     x_acc = mem_word;
                OP_ADD:      x_acc = r_acc + mem_word;
                OP_SUBTRACT: x_acc = r_acc - mem_word;
                OP_BRANCHNEG: begin
                    if (r_acc[31]) begin
                        x_pc = PW'(r_opnd);
                    end
                end
                default:     x_pc = pc_inc;
            endcase
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_idx  = AW'(r_opnd);
        wr_data = r_item.value;
        if (i_cmd.load_en) begin
            wr_en  = addr_ok;
            wr_idx = AW'(r_item.address);
        end else if (i_cmd.exec_en && r_dec_st == ST_OK) begin
            if (r_opc == OP_READ) begin
                wr_en = 1'b1;
            end else if (r_opc == OP_STORE) begin
                wr_en   = 1'b1;
                wr_data = r_acc;
            end
        end
    end

    always_comb begin
        n_res           = '0;
        n_res.status    = ST_OK;
        n_res.pc_now    = 6'(r_pc);
        n_res.acc_now   = r_acc;
        if (i_cmd.restart_en) begin
            n_res.pc_now  = '0;
            n_res.acc_now = '0;
        end else if (i_cmd.report_en) begin
            n_res.read_data = mem_word;
        end else if (i_cmd.exec_en) begin
            n_res.status     = r_dec_st;
            n_res.out_valid  = x_out_valid;
            n_res.out_value  = x_out_valid ? mem_word : 32'sd0;
            n_res.input_used = x_input_used;
            n_res.pc_now     = 6'(x_pc);
            n_res.acc_now    = x_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc    <= '0;
            r_acc   <= '0;
            r_valid <= '0;
        end else begin
            if (i_cmd.restart_en) begin
                r_pc  <= '0;
                r_acc <= '0;
            end else if (i_cmd.exec_en) begin
                r_pc  <= x_pc;
                r_acc <= x_acc;
            end
            if (wr_en) begin
                r_valid[wr_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_mem_q  <= mem[rd_idx];
            r_mem_ok <= rd_ok && r_valid[rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_item;
        end
        if (i_cmd.mul_en) begin
            r_word <= mem_word;
            r_prod <= PROD_W'(mem_word[30:0]) * PROD_W'(DIV_RECIP);
        end
        if (i_cmd.dec_en) begin
            r_opc    <= 6'(quot);
            r_opnd   <= opnd_c;
            r_dec_st <= dec_st_c;
        end
        if (i_cmd.load_en || i_cmd.restart_en || i_cmd.report_en || i_cmd.exec_en) begin
            r_res <= n_res;
        end
    end

    assign o_result = r_res;

endmodule
